// ----- hdl/tsd_pkg.sv -----
// Shared types and constants for the TGA image stream decoder.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none

package tsd_pkg;

   localparam int PAL_ENTRIES     = 256;
   localparam int PAL_AW          = $clog2(PAL_ENTRIES);
   localparam int PAL_ENTRY_BYTES = 3;
   localparam int HDR_BYTES       = 18;
   localparam int HDR_AW          = $clog2(HDR_BYTES);

   // result kinds
   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_PIXEL  = 2'd2;

   // header codes
   localparam logic [7:0] TYPE_RLE_BIT   = 8'h08;
   localparam logic [2:0] TYPE_NONE      = 3'd0;
   localparam logic [2:0] TYPE_GRAY      = 3'd3;
   localparam logic [7:0] DESC_TOP_DOWN  = 8'd32;
   localparam logic [7:0] DESC_BOTTOM_UP = 8'd8;
   localparam logic [7:0] BITS_INDEXED   = 8'd8;
   localparam logic [7:0] BITS_BGR       = 8'd24;
   localparam logic [7:0] BITS_BGRA      = 8'd32;
   localparam logic [7:0] MAP_PRESENT    = 8'd1;
   localparam logic [4:0] MAP_BYTES_BGR  = 5'd3;
   localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

   // CSR map
   localparam int          CSR_AW          = 3;
   localparam logic [2:0]  CSR_FILE_LENGTH = 3'd0;

   typedef struct packed {
      logic [7:0]  ident;
      logic [7:0]  map_type;
      logic [7:0]  img_type;
      logic [15:0] map_start;
      logic [15:0] map_len;
      logic [7:0]  map_bits;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  bits;
      logic [7:0]  desc;
   } hdr_type;

   typedef struct packed {
      logic        ok;
      logic [17:0] pal_off;
      logic [18:0] pal_end;
      logic [21:0] img_off;
   } geom_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [15:0] row;
      logic [15:0] column;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [7:0]  alpha;
      logic        last_pixel;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/tsd_if.sv -----
// Valid/ready channel interfaces for the decoder's byte input and result output.
// Depends on nothing but plain logic types.
`default_nettype none

interface tsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface tsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic [15:0] row;
   logic [15:0] column;
   logic [7:0]  blue;
   logic [7:0]  green;
   logic [7:0]  red;
   logic [7:0]  alpha;
   logic        last_pixel;
   modport source (output valid, output kind, output image_width, output image_height,
                   output row, output column, output blue, output green, output red,
                   output alpha, output last_pixel, input ready);
   modport sink   (input valid, input kind, input image_width, input image_height,
                   input row, input column, input blue, input green, input red,
                   input alpha, input last_pixel, output ready);
endinterface

`default_nettype wire

// ----- hdl/tsd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tsd_hdr_check.sv -----
// Header check sequencer: offsets and image size first, then acceptance.
// Depends on tsd_pkg.
`default_nettype none

module tsd_hdr_check (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire tsd_pkg::hdr_type hdr,
   input  wire logic [31:0]      file_len,
   output logic                  done,
   output tsd_pkg::geom_type     geom
);

   typedef enum logic [1:0] {CK_IDLE, CK_MUL, CK_SUM, CK_CMP} ck_state_type;

   ck_state_type state_ff;
   logic [31:0]  wh_ff;
   logic [23:0]  map_bits_ff;
   logic [39:0]  img_bits_ff;
   logic         done_ff;
   tsd_pkg::geom_type geom_ff;

   logic [37:0] img_end;
   logic        type_ok, bits_ok, desc_ok, pal_ok, len_ok, ok;

   always_comb begin
      img_end = 38'(geom_ff.img_off) + 38'(img_bits_ff[39:3]);
      len_ok  = file_len >= 32'(tsd_pkg::HDR_BYTES);
      type_ok = ((hdr.img_type & tsd_pkg::TYPE_RLE_BIT) == 8'd0)
             && (hdr.img_type[2:0] != tsd_pkg::TYPE_NONE)
             && (hdr.img_type[2:0] != tsd_pkg::TYPE_GRAY);
      desc_ok = (hdr.desc == tsd_pkg::DESC_TOP_DOWN) || (hdr.desc == tsd_pkg::DESC_BOTTOM_UP);
      pal_ok  = (hdr.bits == tsd_pkg::BITS_INDEXED) && (hdr.map_type == tsd_pkg::MAP_PRESENT)
             && (hdr.map_bits[7:3] == tsd_pkg::MAP_BYTES_BGR)
             && ({13'd0, geom_ff.pal_end} <= file_len);
      bits_ok = (hdr.bits == tsd_pkg::BITS_BGR) || (hdr.bits == tsd_pkg::BITS_BGRA) || pal_ok;
      ok      = len_ok && type_ok && (img_end <= {6'd0, file_len}) && desc_ok && bits_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CK_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            CK_IDLE: begin
               if (start) begin
                  state_ff <= CK_MUL;
               end
            end
            CK_MUL: begin
               wh_ff           <= {16'd0, hdr.width} * {16'd0, hdr.height};
               map_bits_ff     <= {8'd0, hdr.map_len} * {16'd0, hdr.map_bits};
               geom_ff.pal_off <= 18'(tsd_pkg::HDR_BYTES) + {2'd0, hdr.map_start}
                                + {10'd0, hdr.ident};
               state_ff        <= CK_SUM;
            end
            CK_SUM: begin
               img_bits_ff     <= {8'd0, wh_ff} * {32'd0, hdr.bits};
               geom_ff.img_off <= {4'd0, geom_ff.pal_off} + {1'd0, map_bits_ff[23:3]};
               geom_ff.pal_end <= {1'd0, geom_ff.pal_off}
                                + 19'({3'd0, hdr.map_len} * 19'(tsd_pkg::PAL_ENTRY_BYTES));
               state_ff        <= CK_CMP;
            end
            CK_CMP: begin
               geom_ff.ok <= ok;
               done_ff    <= 1'b1;
               state_ff   <= CK_IDLE;
            end
            default: state_ff <= CK_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign geom = geom_ff;

endmodule

`default_nettype wire

// ----- hdl/tga_image_stream_decoder.sv -----
// Top level of the TGA image stream decoder: byte datapath, CSR port, palette RAM.
// Depends on tsd_pkg, tsd_if, tsd_ram and tsd_hdr_check.
`default_nettype none

// Takes a TGA file one byte per item and returns, per file, one accept or reject
// item after the 18-byte header, then, if accepted, one pixel item (BGRA, row,
// column) per image pixel. Header, palette and true-color pixel bytes are taken
// one per cycle while the result side keeps up. Byte 17 starts the header check
// (multiplies and bounds compares in the MUL, SUM and CMP states, then a
// registered done hands over the verdict); no byte is taken until the verdict
// item appears. An indexed pixel whose index lies inside the map reads its
// palette entry from a 256 x 24 RAM with registered read data; no byte is taken
// while that read is pending. An index past the map gives black without a read.
// file_length must be written before a file starts; after byte file_length-1
// the decoder restarts on the next file. The palette RAM is not cleared: every
// entry that an accepted indexed image reads is loaded from that same file.
module tga_image_stream_decoder (
   input  wire logic                       clock,
   input  wire logic                       reset,
   tsd_req_if.sink                         req_chan,
   tsd_rsp_if.source                       rsp_chan,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [tsd_pkg::CSR_AW-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output logic      [31:0]                prdata,
   output logic                            pready
);

   typedef enum logic [1:0] {PH_HEADER, PH_CHECK, PH_BODY, PH_DRAIN} phase_type;

   // registers
   phase_type        phase_ff;
   logic [31:0]      file_len_ff;
   logic [31:0]      pos_ff;
   logic [7:0]       hdr_ff [tsd_pkg::HDR_BYTES];
   logic [23:0]      pix_ff;
   logic [1:0]       bip_ff;
   logic [15:0]      col_ff;
   logic [15:0]      row_ff;
   logic [16:0]      pal_idx_ff;
   logic [1:0]       pal_sub_ff;
   logic [15:0]      pal_acc_ff;
   logic             chk_busy_ff;
   logic             pend_ff;
   logic [15:0]      pend_row_ff;
   logic [15:0]      pend_col_ff;
   logic             pend_last_ff;
   logic             rsp_valid_ff;
   tsd_pkg::rsp_type rsp_ff;

   // combinational
   tsd_pkg::hdr_type  hdr;
   tsd_pkg::geom_type geom;
   logic              chk_done;
   logic              accept;
   logic [7:0]        b;
   logic              last;
   logic              in_pal, in_img;
   logic [2:0]        bpp;
   logic              pix_done;
   logic              idx_ok;
   logic              fin;
   logic [15:0]      out_row;
   logic              pal_wr;
   logic [23:0]       pal_rd;
   logic              csr_hit;
   logic              csr_wr;

   assign hdr.ident     = hdr_ff[0];
   assign hdr.map_type  = hdr_ff[1];
   assign hdr.img_type  = hdr_ff[2];
   assign hdr.map_start = {hdr_ff[4], hdr_ff[3]};
   assign hdr.map_len   = {hdr_ff[6], hdr_ff[5]};
   assign hdr.map_bits  = hdr_ff[7];
   assign hdr.width     = {hdr_ff[13], hdr_ff[12]};
   assign hdr.height    = {hdr_ff[15], hdr_ff[14]};
   assign hdr.bits      = hdr_ff[16];
   assign hdr.desc      = hdr_ff[17];

   // items enter when output slot is free or emptying and no check or read waits
   assign req_chan.ready = (!rsp_valid_ff || rsp_chan.ready) && !pend_ff && !chk_busy_ff;
   assign accept = req_chan.valid && req_chan.ready;
   assign b      = req_chan.data_byte;
   assign last   = ({1'b0, pos_ff} + 33'd1) >= {1'b0, file_len_ff};

   always_comb begin
      in_pal   = (hdr.bits == tsd_pkg::BITS_INDEXED)
              && ({1'b0, pos_ff} >= 33'(geom.pal_off))
              && ({1'b0, pos_ff} < 33'(geom.pal_end));
      in_img   = {1'b0, pos_ff} >= 33'(geom.img_off);
      if (hdr.bits == tsd_pkg::BITS_BGRA) begin
         bpp = 3'd4;
      end else if (hdr.bits == tsd_pkg::BITS_BGR) begin
         bpp = 3'd3;
      end else begin
         bpp = 3'd1;
      end
      pix_done = ({1'b0, bip_ff} + 3'd1) >= bpp;
      idx_ok   = ({8'd0, b} < hdr.map_len) && ({1'b0, b} < 9'(tsd_pkg::PAL_ENTRIES));
      fin      = (({1'b0, row_ff} + 17'd1) == {1'b0, hdr.height})
              && (({1'b0, col_ff} + 17'd1) == {1'b0, hdr.width});
      out_row  = (hdr.desc == tsd_pkg::DESC_BOTTOM_UP) ? (hdr.height - 16'd1 - row_ff) : row_ff;
      pal_wr   = accept && (phase_ff == PH_BODY) && in_pal && (pal_sub_ff == 2'd2)
              && (pal_idx_ff < 17'(tsd_pkg::PAL_ENTRIES));
   end

   tsd_hdr_check u_check (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && (phase_ff == PH_HEADER)
                 && (pos_ff == 32'(tsd_pkg::HDR_BYTES - 1))),
      .hdr      (hdr),
      .file_len (file_len_ff),
      .done     (chk_done),
      .geom     (geom)
   );

   tsd_ram #(.WIDTH(24), .DEPTH(tsd_pkg::PAL_ENTRIES)) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr),
      .wr_addr (pal_idx_ff[tsd_pkg::PAL_AW-1:0]),
      .wr_data ({b, pal_acc_ff}),
      .rd_en   (accept && (phase_ff == PH_BODY) && !in_pal && in_img && pix_done
                && (bpp == 3'd1) && idx_ok),
      .rd_addr (b[tsd_pkg::PAL_AW-1:0]),
      .rd_data (pal_rd)
   );

   // CSR: single register, decoded by word address, always ready
   assign pready  = 1'b1;
   assign csr_hit = paddr[tsd_pkg::CSR_AW-1:2]
                 == tsd_pkg::CSR_FILE_LENGTH[tsd_pkg::CSR_AW-1:2];
   assign csr_wr  = psel && penable && pwrite;
   assign prdata  = csr_hit ? file_len_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         file_len_ff  <= 32'd0;
         pos_ff       <= 32'd0;
         pix_ff       <= 24'd0;
         bip_ff       <= 2'd0;
         col_ff       <= 16'd0;
         row_ff       <= 16'd0;
         pal_idx_ff   <= 17'd0;
         pal_sub_ff   <= 2'd0;
         chk_busy_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr && csr_hit) begin
            file_len_ff <= pwdata;
         end
         if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         pend_ff <= 1'b0;

         // palette pixel finishing: RAM data now valid
         if (pend_ff) begin
            rsp_valid_ff      <= 1'b1;
            rsp_ff            <= '0;
            rsp_ff.kind       <= tsd_pkg::KIND_PIXEL;
            rsp_ff.row        <= pend_row_ff;
            rsp_ff.column     <= pend_col_ff;
            rsp_ff.blue       <= pal_rd[7:0];
            rsp_ff.green      <= pal_rd[15:8];
            rsp_ff.red        <= pal_rd[23:16];
            rsp_ff.alpha      <= tsd_pkg::ALPHA_OPAQUE;
            rsp_ff.last_pixel <= pend_last_ff;
         end

         // header verdict
         if (chk_done) begin
            chk_busy_ff         <= 1'b0;
            rsp_valid_ff        <= 1'b1;
            rsp_ff              <= '0;
            rsp_ff.kind         <= geom.ok ? tsd_pkg::KIND_ACCEPT : tsd_pkg::KIND_REJECT;
            rsp_ff.image_width  <= hdr.width;
            rsp_ff.image_height <= hdr.height;
            if (phase_ff == PH_CHECK) begin
               phase_ff <= (geom.ok && (hdr.width != 16'd0) && (hdr.height != 16'd0))
                           ? PH_BODY : PH_DRAIN;
            end
         end

         if (accept) begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (pos_ff < 32'(tsd_pkg::HDR_BYTES)) begin
                     hdr_ff[pos_ff[tsd_pkg::HDR_AW-1:0]] <= b;
                  end
                  if (pos_ff == 32'(tsd_pkg::HDR_BYTES - 1)) begin
                     chk_busy_ff <= 1'b1;
                     phase_ff    <= PH_CHECK;
                  end else if (last) begin
                     // short file: reject with zero size
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '0;
                     rsp_ff.kind  <= tsd_pkg::KIND_REJECT;
                  end
               end
               PH_BODY: begin
                  if (in_pal) begin
                     unique case (pal_sub_ff)
                        2'd0: begin
                           pal_acc_ff[7:0] <= b;
                           pal_sub_ff      <= 2'd1;
                        end
                        2'd1: begin
                           pal_acc_ff[15:8] <= b;
                           pal_sub_ff       <= 2'd2;
                        end
                        default: begin
                           pal_sub_ff <= 2'd0;
                           pal_idx_ff <= pal_idx_ff + 17'd1;
                        end
                     endcase
                  end else if (in_img) begin
                     if (!pix_done) begin
                        unique case (bip_ff)
                           2'd0:    pix_ff[7:0]   <= b;
                           2'd1:    pix_ff[15:8]  <= b;
                           default: pix_ff[23:16] <= b;
                        endcase
                        bip_ff <= bip_ff + 2'd1;
                     end else begin
                        pix_ff <= 24'd0;
                        bip_ff <= 2'd0;
                        if (bpp == 3'd1 && idx_ok) begin
                           pend_ff      <= 1'b1;
                           pend_row_ff  <= out_row;
                           pend_col_ff  <= col_ff;
                           pend_last_ff <= fin;
                        end else begin
                           rsp_valid_ff      <= 1'b1;
                           rsp_ff            <= '0;
                           rsp_ff.kind       <= tsd_pkg::KIND_PIXEL;
                           rsp_ff.row        <= out_row;
                           rsp_ff.column     <= col_ff;
                           rsp_ff.last_pixel <= fin;
                           rsp_ff.alpha      <= tsd_pkg::ALPHA_OPAQUE;
                           if (bpp == 3'd3) begin
                              rsp_ff.blue  <= pix_ff[7:0];
                              rsp_ff.green <= pix_ff[15:8];
                              rsp_ff.red   <= b;
                           end else if (bpp == 3'd4) begin
                              rsp_ff.blue  <= pix_ff[7:0];
                              rsp_ff.green <= pix_ff[15:8];
                              rsp_ff.red   <= pix_ff[23:16];
                              rsp_ff.alpha <= b;
                           end
                        end
                        if (({1'b0, col_ff} + 17'd1) >= {1'b0, hdr.width}) begin
                           col_ff <= 16'd0;
                           row_ff <= row_ff + 16'd1;
                        end else begin
                           col_ff <= col_ff + 16'd1;
                        end
                        if (fin) begin
                           phase_ff <= PH_DRAIN;
                        end
                     end
                  end
               end
               PH_CHECK, PH_DRAIN: begin
               end
               default: begin
               end
            endcase

            // end of file: restart for the next one
            if (last) begin
               pos_ff     <= 32'd0;
               phase_ff   <= PH_HEADER;
               pix_ff     <= 24'd0;
               bip_ff     <= 2'd0;
               col_ff     <= 16'd0;
               row_ff     <= 16'd0;
               pal_idx_ff <= 17'd0;
               pal_sub_ff <= 2'd0;
            end else begin
               pos_ff <= pos_ff + 32'd1;
            end
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_ff.kind;
   assign rsp_chan.image_width  = rsp_ff.image_width;
   assign rsp_chan.image_height = rsp_ff.image_height;
   assign rsp_chan.row          = rsp_ff.row;
   assign rsp_chan.column       = rsp_ff.column;
   assign rsp_chan.blue         = rsp_ff.blue;
   assign rsp_chan.green        = rsp_ff.green;
   assign rsp_chan.red          = rsp_ff.red;
   assign rsp_chan.alpha        = rsp_ff.alpha;
   assign rsp_chan.last_pixel   = rsp_ff.last_pixel;

   // palette read completes without being held over, with no byte taken meanwhile
   a_pend_blocks: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !req_chan.ready) else $error("byte taken during palette read");
   a_pend_once: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> !pend_ff) else $error("palette read held over");
   // header verdict never overwrites a waiting result
   a_chk_slot: assert property (@(posedge clock) disable iff (reset)
      chk_done |-> !rsp_valid_ff) else $error("header verdict with output slot full");
   a_chk_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CHECK) |-> chk_busy_ff) else $error("check phase without check");

endmodule

`default_nettype wire
